// ===== rtl/pdba_pkg.sv =====
// Shared types and constants for the projected distance block averager.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package pdba_pkg;

   // Fixed field and state widths
   localparam int DIST_W  = 16;
   localparam int ANGLE_W = 13;
   localparam int PROJ_W  = 17;
   localparam int COUNT_W = 8;
   localparam int SUM_W   = 25;
   localparam int COS_W   = 16;
   localparam int INDEX_W = 11;

   // Largest window the block averages over
   localparam int MAX_WINDOW = 128;

   // Angle units: sixteenths of a degree
   localparam int QUARTER_TURN = 1440;
   localparam int HALF_TURN    = 2880;
   localparam int FULL_TURN    = 5760;

   // Restoring divider: one quotient bit per step over the sum magnitude
   localparam int DIV_STEPS = SUM_W - 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic rom_read;
      logic mult;
      logic check;
      logic div_step;
      logic load_out;
   } pdba_cmd_type;

   typedef struct packed {
      logic window_full;
      logic div_done;
   } pdba_status_type;

endpackage

`default_nettype wire

// ===== rtl/projected_distance_block_average.sv =====
// Top level of the projected distance block averager.
// Instantiates pdba_controller and pdba_datapath; depends on pdba_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  request | req_distance, req_angle_deg             | req_valid / req_ready
//  result  | rsp_projected, rsp_sample_number,       | rsp_valid / rsp_ready
//          | rsp_mean_valid, rsp_mean                |
//  config  | csr_write_data (window_size)            | csr_write_enable
//
// One transaction at a time: accept, ROM read, multiply, sign/window check,
// then output load; when a window closes, the one-bit-per-cycle restoring
// divider runs between the check and output load. rsp_valid is registered
// and rises with output load.
// A new request is taken as soon as the result sits in the output register,
// even while that result waits on rsp_ready; the controller stalls only at
// output load when the previous result is still untaken.
// Synchronous active-high reset: window_size = 8, running sum and count zero.
//
// Projection uses a 1441-entry quarter-wave cosine ROM (Q1.15) built at
// elaboration; angles are folded by symmetry before the lookup.
`default_nettype none

module projected_distance_block_average
   import pdba_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [DIST_W-1:0]         req_distance,
   input  wire logic signed [ANGLE_W-1:0] req_angle_deg,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [PROJ_W-1:0]       rsp_projected,
   output logic [COUNT_W-1:0]             rsp_sample_number,
   output logic                           rsp_mean_valid,
   output logic signed [PROJ_W-1:0]       rsp_mean,
   input  wire logic                      csr_write_enable,
   input  wire logic [COUNT_W-1:0]        csr_write_data
);

   pdba_cmd_type    cmd;
   pdba_status_type status;

   // FSM: sequencing and handshake flags
   pdba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, window state and output registers
   pdba_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_distance      (req_distance),
      .req_angle_deg     (req_angle_deg),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_projected     (rsp_projected),
      .rsp_sample_number (rsp_sample_number),
      .rsp_mean_valid    (rsp_mean_valid),
      .rsp_mean          (rsp_mean)
   );

   // A result without a closed window carries a zero mean
   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mean_valid) |-> (rsp_mean == '0))
      else $error("mean nonzero without mean_valid");

   // Closing a window restarts the count, so the new sample is number one
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mean_valid) |-> (rsp_sample_number == COUNT_W'(1)))
      else $error("sample_number not one after window close");

   // A new result is only produced by a transaction in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

`default_nettype wire

// ===== rtl/pdba_datapath.sv =====
// Datapath: angle folding, cosine ROM, projection multiply, window state,
// serial divider and result registers. Depends on pdba_pkg.
`default_nettype none

module pdba_datapath
   import pdba_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pdba_cmd_type              cmd,
   output pdba_status_type                status,
   input  wire logic [DIST_W-1:0]         req_distance,
   input  wire logic signed [ANGLE_W-1:0] req_angle_deg,
   input  wire logic                      csr_write_enable,
   input  wire logic [COUNT_W-1:0]        csr_write_data,
   output logic signed [PROJ_W-1:0]       rsp_projected,
   output logic [COUNT_W-1:0]             rsp_sample_number,
   output logic                           rsp_mean_valid,
   output logic signed [PROJ_W-1:0]       rsp_mean
);

   localparam longint PI_Q30  = 64'd3373259426;
   localparam longint ONE_Q30 = 64'd1073741824;

   function automatic longint mul_q30(input longint a, input longint b);
      longint unsigned p;
      p = longint'(a) * longint'(b);
      return longint'(p >> 30);
   endfunction

   // Quarter-wave cosine magnitude, Q1.15, truncated Taylor series in Q30
   function automatic logic [COS_W-1:0] cos_entry(input int k);
      longint x;
      longint y;
      longint t;
      x = (longint'(k) * PI_Q30) / HALF_TURN;
      y = mul_q30(x, x);
      t = ONE_Q30 - y / 90;
      t = ONE_Q30 - mul_q30(y, t) / 56;
      t = ONE_Q30 - mul_q30(y, t) / 30;
      t = ONE_Q30 - mul_q30(y, t) / 12;
      t = ONE_Q30 - mul_q30(y, t) / 2;
      if (t < 0) begin
         t = 0;
      end
      if (t > ONE_Q30) begin
         t = ONE_Q30;
      end
      return COS_W'((t + 16384) >>> 15);
   endfunction

   // Constant ROM, one entry per sixteenth of a degree over a quarter turn
   logic [COS_W-1:0] cos_rom [0:QUARTER_TURN];

   for (genvar k = 0; k <= QUARTER_TURN; k++) begin : g_cos_rom
      localparam logic [COS_W-1:0] COS_VAL = cos_entry(k);
      assign cos_rom[k] = COS_VAL;
   end

   // Angle folding into the first quadrant
   logic signed [ANGLE_W:0] ang_ext;
   logic [ANGLE_W-1:0]      ang_abs;
   logic [ANGLE_W-1:0]      ang_fold;
   logic [ANGLE_W-1:0]      ang_quad;
   logic                    ang_neg;

   always_comb begin
      ang_ext = {req_angle_deg[ANGLE_W-1], req_angle_deg};
      ang_abs = ang_ext[ANGLE_W] ? ANGLE_W'(-ang_ext) : ANGLE_W'(ang_ext);
      ang_fold = (ang_abs > ANGLE_W'(HALF_TURN)) ? ANGLE_W'(FULL_TURN) - ang_abs : ang_abs;
      ang_neg = (ang_fold > ANGLE_W'(QUARTER_TURN));
      ang_quad = ang_neg ? ANGLE_W'(HALF_TURN) - ang_fold : ang_fold;
   end

   // Item registers
   logic [DIST_W-1:0]          dist_ff;
   logic [INDEX_W-1:0]         index_ff;
   logic                       neg_ff;
   logic [COS_W-1:0]           cos_q_ff;
   logic [2*DIST_W-1:0]        prod_ff;
   logic signed [PROJ_W-1:0]   proj_ff;
   logic                       full_ff;

   // Window state
   logic [COUNT_W-1:0]         win_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic [COUNT_W-1:0]         win_eff;

   // Divider
   logic [DIV_STEPS-1:0]       quot_ff;
   logic [COUNT_W-1:0]         rem_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       sum_neg_ff;
   logic [COUNT_W:0]           shifted;
   logic [COUNT_W:0]           trial;
   logic                       trial_ok;
   logic [SUM_W-1:0]           sum_abs;
   logic [PROJ_W-1:0]          mag;
   logic signed [PROJ_W-1:0]   quot_s;
   logic signed [PROJ_W-1:0]   mean_in;

   always_comb begin
      if (win_ff == '0) begin
         win_eff = COUNT_W'(1);
      end else if (int'(win_ff) > MAX_WINDOW) begin
         win_eff = COUNT_W'(MAX_WINDOW);
      end else begin
         win_eff = win_ff;
      end
      status.window_full = (count_ff >= win_eff);
      status.div_done = (step_ff == STEP_W'(DIV_STEPS - 1));

      mag = prod_ff[2*DIST_W-1:15];
      sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

      shifted = {rem_ff, quot_ff[DIV_STEPS-1]};
      trial = shifted - {1'b0, count_ff};
      trial_ok = (shifted >= {1'b0, count_ff});

      quot_s = quot_ff[PROJ_W-1:0];
      if (full_ff) begin
         mean_in = sum_neg_ff ? -quot_s : quot_s;
         sum_in = {{(SUM_W-PROJ_W){proj_ff[PROJ_W-1]}}, proj_ff};
         count_in = COUNT_W'(1);
      end else begin
         mean_in = '0;
         sum_in = sum_ff + {{(SUM_W-PROJ_W){proj_ff[PROJ_W-1]}}, proj_ff};
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= COUNT_W'(8);
         count_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            win_ff <= csr_write_data;
         end
         if (cmd.load_out) begin
            count_ff <= count_in;
            sum_ff <= sum_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dist_ff <= req_distance;
         index_ff <= INDEX_W'(ang_quad);
         neg_ff <= ang_neg;
      end
      if (cmd.rom_read) begin
         cos_q_ff <= cos_rom[index_ff];
      end
      if (cmd.mult) begin
         prod_ff <= (2*DIST_W)'(dist_ff) * (2*DIST_W)'(cos_q_ff);
      end
      if (cmd.check) begin
         proj_ff <= neg_ff ? -mag : mag;
         full_ff <= status.window_full;
         sum_neg_ff <= sum_ff[SUM_W-1];
         quot_ff <= sum_abs[DIV_STEPS-1:0];
         rem_ff <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ok ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
         quot_ff <= {quot_ff[DIV_STEPS-2:0], trial_ok};
         step_ff <= step_ff + STEP_W'(1);
      end
      if (cmd.load_out) begin
         rsp_projected <= proj_ff;
         rsp_sample_number <= count_in;
         rsp_mean_valid <= full_ff;
         rsp_mean <= mean_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pdba_controller.sv =====
// Controller: sequences lookup, multiply, check, divide on window close
// and output load, one item at a time; owns handshake flags. Uses pdba_pkg.
`default_nettype none

module pdba_controller
   import pdba_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire pdba_status_type status,
   output pdba_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_MULT,
      S_CHECK,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.capture = req_valid;
         S_LOOKUP: cmd.rom_read = 1'b1;
         S_MULT:   cmd.mult = 1'b1;
         S_CHECK:  cmd.check = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_DONE:   cmd.load_out = !rsp_valid_ff || rsp_ready;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new load replaces a result taken in the same cycle
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd.capture) begin
                  req_ready_ff <= 1'b0;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: state_ff <= S_MULT;
            S_MULT:   state_ff <= S_CHECK;
            S_CHECK: begin
               state_ff <= status.window_full ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (status.div_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (cmd.load_out) begin
                  req_ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
